>>> design/rv32ie_pkg.sv
// ---------------------------------------------------------------------------
// rv32ie_pkg
// Shared types and constants for the RV32I integer execute block: the
// instruction class codes, funct3 codes, item and result records.
// ---------------------------------------------------------------------------
package rv32ie_pkg;

   // data path and register file geometry
   localparam int XLEN       = 32;
   localparam int RF_DEPTH   = 32;
   localparam int RF_IDX_W   = 5;

   // fixed encodings
   localparam logic [6:0]      ALT_FUNCT7    = 7'h20;
   localparam logic [6:0]      MULDIV_FUNCT7 = 7'h01;
   localparam logic [XLEN-1:0] INSTR_BYTES   = 32'd4;
   localparam logic [XLEN-1:0] JALR_MASK     = ~32'd1;
   localparam int              SHAMT_W       = 5;

   // stream widths
   localparam int REQ_TDATA_W = 96;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 72;

   // instruction class
   typedef enum logic [2:0] {
      ACT_LUI    = 3'd0,
      ACT_AUIPC  = 3'd1,
      ACT_OP_IMM = 3'd2,
      ACT_OP     = 3'd3,
      ACT_BRANCH = 3'd4,
      ACT_JAL    = 3'd5,
      ACT_JALR   = 3'd6,
      ACT_FENCE  = 3'd7
   } action_type;

   // alu funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // branch funct3 codes
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // one decoded instruction
   typedef struct packed {
      action_type               action;
      logic [2:0]               funct3;
      logic [6:0]               funct7;
      logic [RF_IDX_W-1:0]      dest_reg;
      logic [RF_IDX_W-1:0]      src1_reg;
      logic [RF_IDX_W-1:0]      src2_reg;
      logic signed [XLEN-1:0]   immediate;
      logic [XLEN-1:0]          instr_pc;
   } item_type;

   // one result, packed with next_pc in the lowest bits
   typedef struct packed {
      logic                     illegal;
      logic                     branch_taken;
      logic [XLEN-1:0]          write_value;
      logic [RF_IDX_W-1:0]      write_index;
      logic                     write_enable;
      logic [XLEN-1:0]          next_pc;
   } result_type;

endpackage

>>> design/rv32i_integer_execute_top.sv
// ---------------------------------------------------------------------------
// rv32i_integer_execute_top
// RV32I integer execute stage with a 32-entry register file and bypass.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one decoded instruction per transfer; req_tuser holds the
//    instruction class, req_tdata the remaining fields.
//  - rsp_* returns exactly one result per instruction, in order: next pc,
//    register write-back, branch-taken and illegal flags.
//  - an accepted instruction is latched with its operands into the operand
//    stage; its result is then registered into the output register on rsp_*.
//  - throughput: one instruction per clock while rsp_* is not stalled. The
//    operands are read from the register file at acceptance; the result of
//    the instruction just ahead is forwarded from the output register, so
//    dependent back-to-back instructions run at full rate.
//  - the register file is written when an instruction moves into the
//    output register, so later instructions always see its effect.
//  - reset clears all registers to zero (per-entry valid bits, no clearing
//    pass) and empties both pipeline stages.
//  - when rsp_tready is low with a result pending, the operand stage holds
//    one more instruction and then req_tready drops until the result is
//    taken.
// ---------------------------------------------------------------------------
module rv32i_integer_execute_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // funct3, funct7, dest_reg, src1_reg, src2_reg, immediate, instr_pc, zero pad
   input  logic [rv32ie_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // action
   input  logic [rv32ie_pkg::REQ_TUSER_W-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // next_pc, write_enable, write_index, write_value, branch_taken, illegal
   output logic [rv32ie_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import rv32ie_pkg::*;

   item_type        req_item;
   logic            req_accept;
   logic            s1_advance;
   logic            s1_move;
   logic            s1_valid_ff;
   logic            s1_valid_in;
   item_type        s1_item_ff;
   logic            fwd1_ff;
   logic            fwd2_ff;
   logic            fwd1_in;
   logic            fwd2_in;
   logic [XLEN-1:0] rf_data1;
   logic [XLEN-1:0] rf_data2;
   logic [XLEN-1:0] src1_value;
   logic [XLEN-1:0] src2_value;
   result_type      ex_result;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   result_type      rsp_result_ff;

   // unpack the request
   always_comb begin
      req_item.action    = action_type'(req_tuser[2:0]);
      req_item.funct3    = req_tdata[2:0];
      req_item.funct7    = req_tdata[9:3];
      req_item.dest_reg  = req_tdata[14:10];
      req_item.src1_reg  = req_tdata[19:15];
      req_item.src2_reg  = req_tdata[24:20];
      req_item.immediate = $signed(req_tdata[56:25]);
      req_item.instr_pc  = req_tdata[88:57];
   end

   // handshake
   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s1_advance;
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // forward from the instruction leaving execute in the same cycle
   assign fwd1_in = s1_valid_ff && ex_result.write_enable
                    && (ex_result.write_index == req_item.src1_reg);
   assign fwd2_in = s1_valid_ff && ex_result.write_enable
                    && (ex_result.write_index == req_item.src2_reg);

   // operand stage control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // operand stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_item;
         fwd1_ff    <= fwd1_in;
         fwd2_ff    <= fwd2_in;
      end
   end

   // register file
   rv32ie_regfile u_regfile (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_move && ex_result.write_enable),
      .wr_idx   (ex_result.write_index),
      .wr_data  (ex_result.write_value),
      .rd_en    (req_accept),
      .rd_idx1  (req_item.src1_reg),
      .rd_idx2  (req_item.src2_reg),
      .rd_data1 (rf_data1),
      .rd_data2 (rf_data2)
   );

   // operand bypass from the output register
   assign src1_value = fwd1_ff ? rsp_result_ff.write_value : rf_data1;
   assign src2_value = fwd2_ff ? rsp_result_ff.write_value : rf_data2;

   // execute
   rv32ie_alu u_alu (
      .item       (s1_item_ff),
      .src1_value (src1_value),
      .src2_value (src2_value),
      .result     (ex_result)
   );

   // result register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_result_ff <= ex_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_result_ff;

`ifndef SYNTHESIS
   // an illegal encoding never writes back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.illegal |-> !rsp_result_ff.write_enable)
      else $error("illegal instruction reported a write-back");

   // register 0 is never the write target
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.write_enable |-> rsp_result_ff.write_index != '0)
      else $error("write-back to register 0");

   // an executed instruction always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("executed instruction lost");

   // full pipe with a stalled receiver must not take a new instruction
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request accepted while pipeline full and stalled");

   // a held result stays put while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_result_ff) && !s1_move || rsp_tready)
      else $error("stalled result changed");
`endif

endmodule

>>> design/rv32ie_regfile.sv
// ---------------------------------------------------------------------------
// rv32ie_regfile
// 32 x 32 integer register file: one write port, two read ports with
// registered read data. Per-entry valid bits make unwritten entries read
// as zero right after reset; register 0 is never written by the ALU and reads zero.
// ---------------------------------------------------------------------------
module rv32ie_regfile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [rv32ie_pkg::RF_IDX_W-1:0] wr_idx,
   input  logic [rv32ie_pkg::XLEN-1:0]     wr_data,
   input  logic                           rd_en,
   input  logic [rv32ie_pkg::RF_IDX_W-1:0] rd_idx1,
   input  logic [rv32ie_pkg::RF_IDX_W-1:0] rd_idx2,
   output logic [rv32ie_pkg::XLEN-1:0]     rd_data1,
   output logic [rv32ie_pkg::XLEN-1:0]     rd_data2
);
   import rv32ie_pkg::*;

   logic [XLEN-1:0]     mem [RF_DEPTH];
   logic [RF_DEPTH-1:0] valid_ff;
   logic [XLEN-1:0]     rd_data1_ff;
   logic [XLEN-1:0]     rd_data2_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // registered reads, unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data1_ff <= valid_ff[rd_idx1] ? mem[rd_idx1] : '0;
         rd_data2_ff <= valid_ff[rd_idx2] ? mem[rd_idx2] : '0;
      end
   end

   assign rd_data1 = rd_data1_ff;
   assign rd_data2 = rd_data2_ff;

endmodule

>>> design/rv32ie_alu.sv
// ---------------------------------------------------------------------------
// rv32ie_alu
// Combinational execute logic: ALU, branch compare, jump target and
// write-back selection for one instruction and its two operands.
// ---------------------------------------------------------------------------
module rv32ie_alu (
   input  rv32ie_pkg::item_type        item,
   input  logic [rv32ie_pkg::XLEN-1:0] src1_value,
   input  logic [rv32ie_pkg::XLEN-1:0] src2_value,
   output rv32ie_pkg::result_type      result
);
   import rv32ie_pkg::*;

   logic [XLEN-1:0]    imm_u;
   logic [XLEN-1:0]    opnd_b;
   logic               alt;
   logic               do_sub;
   logic [SHAMT_W-1:0] shamt;
   logic [XLEN-1:0]    alu_value;
   logic [XLEN-1:0]    pc_plus4;
   logic [XLEN-1:0]    pc_target;
   logic               cond_true;
   logic               cond_bad;
   logic [XLEN-1:0]    value;
   logic [XLEN-1:0]    npc;
   logic               wr;
   logic               wr_final;
   logic               taken;
   logic               bad;

   assign imm_u     = item.immediate;
   assign opnd_b    = (item.action == ACT_OP) ? src2_value : imm_u;
   assign alt       = (item.funct7 == ALT_FUNCT7);
   assign do_sub    = alt && (item.action == ACT_OP);
   assign shamt     = opnd_b[SHAMT_W-1:0];
   assign pc_plus4  = item.instr_pc + INSTR_BYTES;
   assign pc_target = item.instr_pc + imm_u;

   // shared alu for op and op_imm
   always_comb begin
      case (item.funct3)
         F3_ADD:  alu_value = do_sub ? (src1_value - opnd_b) : (src1_value + opnd_b);
         F3_SLL:  alu_value = src1_value << shamt;
         F3_SLT:  alu_value = {{(XLEN-1){1'b0}},
                               ($signed(src1_value) < $signed(opnd_b))};
         F3_SLTU: alu_value = {{(XLEN-1){1'b0}}, (src1_value < opnd_b)};
         F3_XOR:  alu_value = src1_value ^ opnd_b;
         F3_SR:   alu_value = alt ? XLEN'($signed(src1_value) >>> shamt)
                                  : (src1_value >> shamt);
         F3_OR:   alu_value = src1_value | opnd_b;
         F3_AND:  alu_value = src1_value & opnd_b;
         default: alu_value = '0;
      endcase
   end

   // branch condition
   always_comb begin
      cond_bad = 1'b0;
      case (item.funct3)
         F3_BEQ:  cond_true = (src1_value == src2_value);
         F3_BNE:  cond_true = (src1_value != src2_value);
         F3_BLT:  cond_true = ($signed(src1_value) < $signed(src2_value));
         F3_BGE:  cond_true = !($signed(src1_value) < $signed(src2_value));
         F3_BLTU: cond_true = (src1_value < src2_value);
         F3_BGEU: cond_true = (src1_value >= src2_value);
         default: begin
            cond_true = 1'b0;
            cond_bad  = 1'b1;
         end
      endcase
   end

   // per-class selection
   always_comb begin
      value = '0;
      npc   = pc_plus4;
      wr    = 1'b0;
      taken = 1'b0;
      bad   = 1'b0;
      case (item.action)
         ACT_LUI: begin
            value = imm_u;
            wr    = 1'b1;
         end
         ACT_AUIPC: begin
            value = pc_target;
            wr    = 1'b1;
         end
         ACT_OP_IMM: begin
            value = alu_value;
            wr    = 1'b1;
         end
         ACT_OP: begin
            if (item.funct7 == MULDIV_FUNCT7) begin
               bad = 1'b1;
            end else begin
               value = alu_value;
               wr    = 1'b1;
            end
         end
         ACT_BRANCH: begin
            taken = cond_true;
            bad   = cond_bad;
            if (cond_true) begin
               npc = pc_target;
            end
         end
         ACT_JAL: begin
            value = pc_plus4;
            wr    = 1'b1;
            npc   = pc_target;
         end
         ACT_JALR: begin
            value = pc_plus4;
            wr    = 1'b1;
            npc   = (src1_value + imm_u) & JALR_MASK;
         end
         ACT_FENCE: begin
            wr = 1'b0;
         end
         default: begin
            wr = 1'b0;
         end
      endcase
   end

   // register 0 is never written; no write-back reports zeros
   assign wr_final            = wr && (item.dest_reg != '0);
   assign result.next_pc      = npc;
   assign result.write_enable = wr_final;
   assign result.write_index  = wr_final ? item.dest_reg : '0;
   assign result.write_value  = wr_final ? value : '0;
   assign result.branch_taken = taken;
   assign result.illegal      = bad;

endmodule
